/* src/bst_pkg.sv */
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, token codes and keyword tables of the source tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int LINE_OUT_W    = 16;
  localparam int CODE_W        = 6;
  localparam int CHAR_W        = 8;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // keyword matching
  localparam int KW_NUM     = 23;
  localparam int KW_MAX_LEN = 8;
  localparam int KW_LEN_W   = 4;
  localparam logic [KW_LEN_W-1:0] KW_LEN_SAT = KW_LEN_W'(KW_MAX_LEN + 1);

  // token codes
  localparam logic [CODE_W-1:0] TK_NULL   = 6'd0;
  localparam logic [CODE_W-1:0] TK_EOF    = 6'd1;
  localparam logic [CODE_W-1:0] TK_EOL    = 6'd2;
  localparam logic [CODE_W-1:0] TK_INT    = 6'd3;
  localparam logic [CODE_W-1:0] TK_REAL   = 6'd4;
  localparam logic [CODE_W-1:0] TK_IDENT  = 6'd5;
  localparam logic [CODE_W-1:0] TK_KW0    = 6'd6;
  localparam logic [CODE_W-1:0] TK_LPAREN = 6'd29;
  localparam logic [CODE_W-1:0] TK_RPAREN = 6'd30;
  localparam logic [CODE_W-1:0] TK_COMMA  = 6'd31;
  localparam logic [CODE_W-1:0] TK_PLUS   = 6'd32;
  localparam logic [CODE_W-1:0] TK_MINUS  = 6'd33;
  localparam logic [CODE_W-1:0] TK_STAR   = 6'd34;
  localparam logic [CODE_W-1:0] TK_SLASH  = 6'd35;
  localparam logic [CODE_W-1:0] TK_BSLASH = 6'd36;
  localparam logic [CODE_W-1:0] TK_CARET  = 6'd37;
  localparam logic [CODE_W-1:0] TK_EQ     = 6'd38;
  localparam logic [CODE_W-1:0] TK_NE     = 6'd39;
  localparam logic [CODE_W-1:0] TK_LE     = 6'd40;
  localparam logic [CODE_W-1:0] TK_GE     = 6'd41;
  localparam logic [CODE_W-1:0] TK_LT     = 6'd42;
  localparam logic [CODE_W-1:0] TK_GT     = 6'd43;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_COMMENT = 7'b0000010,
    M_INT     = 7'b0000100,
    M_REAL    = 7'b0001000,
    M_WORD    = 7'b0010000,
    M_LT      = 7'b0100000,
    M_GT      = 7'b1000000
  } mode_t;

  typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;
  typedef logic [KW_NUM-1:0]       kw_mask_t;

  // right justified, zero padded
  localparam kw_text_t KW_TEXT [KW_NUM] = '{
    "declare", "dim", "as", "type", "true", "false", "end", "sub",
    "function", "return", "if", "then", "elseif", "else", "for", "to",
    "step", "while", "input", "print", "and", "or", "not"
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_NUM] = '{
    4'd7, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd3,
    4'd8, 4'd6, 4'd2, 4'd4, 4'd6, 4'd4, 4'd3, 4'd2,
    4'd4, 4'd5, 4'd5, 4'd5, 4'd3, 4'd2, 4'd3
  };

  typedef struct packed {
    logic                  kind;
    logic [CODE_W-1:0]     code;
    logic [CHAR_W-1:0]     chr;
    logic [LINE_OUT_W-1:0] line;
    logic                  last;
  } res_t;

endpackage

/* src/basic_source_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// basic_source_tokenizer_unit
// Streaming BASIC lexer: one character or end mark in, tokens and lexeme
// character echoes out.
// ----------------------------------------------------------------------------
//  port group   dir   handshake               payload
//  in_*         in    in_valid / in_ready     ch, at_end
//  out_*        out   out_valid / out_ready   kind, token_code, lexeme_char,
//                                             line_number, last_of_run
//
// one character is taken per cycle; its zero to two results enter a four-entry
// result queue at the accepting edge and leave one per cycle from the next one
// in_ready is high while the queue holds two results or fewer; only one result
// leaves per cycle, so characters that give two results fill the queue and drop
// in_ready even with out_ready high, as does any out_ready stall
// synchronous active-low reset returns the scanner to idle, line count zero
// ----------------------------------------------------------------------------
module basic_source_tokenizer_unit #(
  parameter int LINE_BITS = bst_pkg::LINE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bst_pkg::CHAR_W-1:0]        in_ch,
  input  logic                              in_at_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [bst_pkg::CODE_W-1:0]        out_token_code,
  output logic [bst_pkg::CHAR_W-1:0]        out_lexeme_char,
  output logic [bst_pkg::LINE_OUT_W-1:0]    out_line_number,
  output logic                              out_last_of_run
);

  logic           fire;
  logic [1:0]     push_n;
  bst_pkg::res_t  res0, res1, head;

  assign fire = in_valid && in_ready;

  bst_scan #(
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (fire),
    .ch_i     (in_ch),
    .at_end_i (in_at_end),
    .push_n_o (push_n),
    .res0_o   (res0),
    .res1_o   (res1)
  );

  bst_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n_i (fire ? push_n : 2'd0),
    .res0_i   (res0),
    .res1_i   (res1),
    .room2_o  (in_ready),
    .valid_o  (out_valid),
    .ready_i  (out_ready),
    .head_o   (head)
  );

  assign out_kind        = head.kind;
  assign out_token_code  = head.code;
  assign out_lexeme_char = head.chr;
  assign out_line_number = head.line;
  assign out_last_of_run = head.last;

endmodule

/* src/bst_kw.sv */
// ----------------------------------------------------------------------------
// bst_kw
// Keyword candidate tracking: narrows the set of keywords still matching the
// word prefix and resolves the token code when the word ends.
// ----------------------------------------------------------------------------
module bst_kw (
  input  bst_pkg::kw_mask_t               mask_i,
  input  logic [bst_pkg::KW_LEN_W-1:0]    len_i,
  input  logic [bst_pkg::CHAR_W-1:0]      char_i,
  output bst_pkg::kw_mask_t               grow_mask_o,
  output bst_pkg::kw_mask_t               start_mask_o,
  output logic [bst_pkg::CODE_W-1:0]      code_o
);

  // keyword character at position p, zero past its end
  function automatic logic [bst_pkg::CHAR_W-1:0] kw_char(
    input int                           k,
    input logic [bst_pkg::KW_LEN_W-1:0] p
  );
    bst_pkg::kw_text_t              t;
    logic [bst_pkg::KW_LEN_W-1:0]   l;
    logic [bst_pkg::CHAR_W-1:0]     r;
    t = bst_pkg::KW_TEXT[k];
    l = bst_pkg::KW_LEN[k];
    r = '0;
    if (p < l) begin
      r = t[8*(l - p - 4'd1) +: 8];
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < bst_pkg::KW_NUM; k++) begin
      grow_mask_o[k]  = mask_i[k] && (kw_char(k, len_i) == char_i);
      start_mask_o[k] = (kw_char(k, '0) == char_i);
    end
  end

  always_comb begin
    code_o = bst_pkg::TK_IDENT;
    for (int k = bst_pkg::KW_NUM - 1; k >= 0; k--) begin
      if (mask_i[k] && (bst_pkg::KW_LEN[k] == len_i)) begin
        code_o = bst_pkg::TK_KW0 + bst_pkg::CODE_W'(k);
      end
    end
  end

endmodule

/* src/bst_scan.sv */
// ----------------------------------------------------------------------------
// bst_scan
// Scanner state and per-character result logic; produces up to two results
// for each accepted character.
// ----------------------------------------------------------------------------
module bst_scan #(
  parameter int LINE_BITS = bst_pkg::LINE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire_i,
  input  logic [bst_pkg::CHAR_W-1:0]   ch_i,
  input  logic                         at_end_i,
  output logic [1:0]                   push_n_o,
  output bst_pkg::res_t                res0_o,
  output bst_pkg::res_t                res1_o
);

  bst_pkg::mode_t                mode_r, mode_nxt;
  logic [bst_pkg::KW_LEN_W-1:0]  len_r, len_nxt;
  bst_pkg::kw_mask_t             mask_r, mask_nxt;
  logic [LINE_BITS-1:0]          line_r, line_nxt;

  bst_pkg::kw_mask_t             grow_mask;
  bst_pkg::kw_mask_t             start_mask;
  logic [bst_pkg::CODE_W-1:0]    word_code;

  logic [bst_pkg::CHAR_W-1:0]    lc;
  logic                          is_digit;
  logic                          is_alpha;
  logic                          fresh;
  logic                          a_v, b_v;
  bst_pkg::res_t                 a, b;

  function automatic bst_pkg::res_t mk(
    input logic                       kind,
    input logic [bst_pkg::CODE_W-1:0] code,
    input logic [bst_pkg::CHAR_W-1:0] chr
  );
    bst_pkg::res_t r;
    r      = '0;
    r.kind = kind;
    r.code = code;
    r.chr  = chr;
    return r;
  endfunction

  bst_kw u_kw (
    .mask_i       (mask_r),
    .len_i        (len_r),
    .char_i       (lc),
    .grow_mask_o  (grow_mask),
    .start_mask_o (start_mask),
    .code_o       (word_code)
  );

  always_comb begin
    is_digit = ch_i inside {["0":"9"]};
    is_alpha = ch_i inside {["a":"z"], ["A":"Z"]};
    lc       = (ch_i inside {["A":"Z"]}) ? (ch_i | 8'h20) : ch_i;
  end

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    mask_nxt = mask_r;
    line_nxt = line_r;
    fresh    = 1'b0;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a        = '0;
    b        = '0;

    if (at_end_i) begin
      // flush the pending token, then eof
      case (mode_r)
        bst_pkg::M_INT: begin
          a_v = 1'b1;
          a   = mk(1'b0, bst_pkg::TK_INT, '0);
        end
        bst_pkg::M_REAL: begin
          a_v = 1'b1;
          a   = mk(1'b0, bst_pkg::TK_REAL, '0);
        end
        bst_pkg::M_WORD: begin
          a_v = 1'b1;
          a   = mk(1'b0, word_code, '0);
        end
        bst_pkg::M_LT: begin
          a_v = 1'b1;
          a   = mk(1'b0, bst_pkg::TK_LT, '0);
        end
        bst_pkg::M_GT: begin
          a_v = 1'b1;
          a   = mk(1'b0, bst_pkg::TK_GT, '0);
        end
        default: begin
        end
      endcase
      b_v      = 1'b1;
      b        = mk(1'b0, bst_pkg::TK_EOF, '0);
      mode_nxt = bst_pkg::M_IDLE;
      len_nxt  = '0;
    end else begin
      case (mode_r)
        bst_pkg::M_COMMENT: begin
          if (ch_i == "\n") begin
            fresh = 1'b1;
          end
        end
        bst_pkg::M_INT: begin
          if (is_digit) begin
            a_v = 1'b1;
            a   = mk(1'b1, bst_pkg::TK_NULL, ch_i);
          end else if (ch_i == ".") begin
            mode_nxt = bst_pkg::M_REAL;
            a_v      = 1'b1;
            a        = mk(1'b1, bst_pkg::TK_NULL, ch_i);
          end else begin
            a_v   = 1'b1;
            a     = mk(1'b0, bst_pkg::TK_INT, '0);
            fresh = 1'b1;
          end
        end
        bst_pkg::M_REAL: begin
          if (is_digit) begin
            a_v = 1'b1;
            a   = mk(1'b1, bst_pkg::TK_NULL, ch_i);
          end else begin
            a_v   = 1'b1;
            a     = mk(1'b0, bst_pkg::TK_REAL, '0);
            fresh = 1'b1;
          end
        end
        bst_pkg::M_WORD: begin
          if (is_digit || is_alpha) begin
            mask_nxt = grow_mask;
            len_nxt  = (len_r == bst_pkg::KW_LEN_SAT) ? len_r : len_r + 4'd1;
            a_v      = 1'b1;
            a        = mk(1'b1, bst_pkg::TK_NULL, lc);
          end else begin
            a_v     = 1'b1;
            a       = mk(1'b0, word_code, '0);
            len_nxt = '0;
            fresh   = 1'b1;
          end
        end
        bst_pkg::M_LT: begin
          mode_nxt = bst_pkg::M_IDLE;
          a_v      = 1'b1;
          if (ch_i == ">") begin
            a = mk(1'b0, bst_pkg::TK_NE, '0);
          end else if (ch_i == "=") begin
            a = mk(1'b0, bst_pkg::TK_LE, '0);
          end else begin
            a     = mk(1'b0, bst_pkg::TK_LT, '0);
            fresh = 1'b1;
          end
        end
        bst_pkg::M_GT: begin
          mode_nxt = bst_pkg::M_IDLE;
          a_v      = 1'b1;
          if (ch_i == "=") begin
            a = mk(1'b0, bst_pkg::TK_GE, '0);
          end else begin
            a     = mk(1'b0, bst_pkg::TK_GT, '0);
            fresh = 1'b1;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      // character handled as if nothing were pending
      if (fresh) begin
        mode_nxt = bst_pkg::M_IDLE;
        if (ch_i == " " || ch_i == "\t") begin
        end else if (ch_i == "'") begin
          mode_nxt = bst_pkg::M_COMMENT;
        end else if (ch_i == "\n") begin
          line_nxt = line_r + 1'b1;
          b_v      = 1'b1;
          b        = mk(1'b0, bst_pkg::TK_EOL, '0);
        end else if (is_digit) begin
          mode_nxt = bst_pkg::M_INT;
          b_v      = 1'b1;
          b        = mk(1'b1, bst_pkg::TK_NULL, ch_i);
        end else if (is_alpha) begin
          mode_nxt = bst_pkg::M_WORD;
          mask_nxt = start_mask;
          len_nxt  = 4'd1;
          b_v      = 1'b1;
          b        = mk(1'b1, bst_pkg::TK_NULL, lc);
        end else if (ch_i == "<") begin
          mode_nxt = bst_pkg::M_LT;
        end else if (ch_i == ">") begin
          mode_nxt = bst_pkg::M_GT;
        end else begin
          b_v = 1'b1;
          case (ch_i)
            "(":     b = mk(1'b0, bst_pkg::TK_LPAREN, '0);
            ")":     b = mk(1'b0, bst_pkg::TK_RPAREN, '0);
            ",":     b = mk(1'b0, bst_pkg::TK_COMMA, '0);
            "+":     b = mk(1'b0, bst_pkg::TK_PLUS, '0);
            "-":     b = mk(1'b0, bst_pkg::TK_MINUS, '0);
            "*":     b = mk(1'b0, bst_pkg::TK_STAR, '0);
            "/":     b = mk(1'b0, bst_pkg::TK_SLASH, '0);
            "\\":    b = mk(1'b0, bst_pkg::TK_BSLASH, '0);
            "^":     b = mk(1'b0, bst_pkg::TK_CARET, '0);
            "=":     b = mk(1'b0, bst_pkg::TK_EQ, '0);
            default: b = mk(1'b0, bst_pkg::TK_NULL, '0);
          endcase
        end
      end
    end

    // a token closed by this character sees the old line count
    a.line = bst_pkg::LINE_OUT_W'(line_r);
    b.line = bst_pkg::LINE_OUT_W'(line_nxt);
  end

  always_comb begin
    push_n_o = {1'b0, a_v} + {1'b0, b_v};
    res0_o   = a_v ? a : b;
    res1_o   = b;
    res0_o.last = !(a_v && b_v);
    res1_o.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bst_pkg::M_IDLE;
      len_r  <= '0;
      line_r <= '0;
    end else if (fire_i) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_i) begin
      mask_r <= mask_nxt;
    end
  end

endmodule

/* src/bst_res_fifo.sv */
// ----------------------------------------------------------------------------
// bst_res_fifo
// Small result queue: up to two results in, one out when ready, each cycle.
// ----------------------------------------------------------------------------
module bst_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_n_i,
  input  bst_pkg::res_t   res0_i,
  input  bst_pkg::res_t   res1_i,
  output logic            room2_o,
  output logic            valid_o,
  input  logic            ready_i,
  output bst_pkg::res_t   head_o
);

  bst_pkg::res_t                  mem_r [bst_pkg::RES_DEPTH];
  logic [bst_pkg::RES_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bst_pkg::RES_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bst_pkg::RES_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bst_pkg::RES_PTR_W-1:0]  wr_ptr_p1;
  logic                           pop;

  always_comb begin
    pop        = valid_o && ready_i;
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + bst_pkg::RES_PTR_W'(push_n_i);
    rd_ptr_nxt = rd_ptr_r + bst_pkg::RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + bst_pkg::RES_CNT_W'(push_n_i) - bst_pkg::RES_CNT_W'(pop);
  end

  assign valid_o = (cnt_r != '0);
  assign room2_o = (cnt_r <= bst_pkg::RES_CNT_W'(bst_pkg::RES_DEPTH - 2));
  assign head_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n_i != 2'd0) begin
      mem_r[wr_ptr_r] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_r[wr_ptr_p1] <= res1_i;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming BASIC tokenizer. A driver streams
// source characters and end marks from a queue; a built-in lexer predicts the
// token and echo results of every accepted transfer, and a monitor compares
// the results in order, under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import bst_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SOURCE_ITEMS = 850;
  localparam int GAP_PCT      = 9;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              at_end;
  } src_item_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_ch     = '0;
  logic                  in_at_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_kind;
  logic [CODE_W-1:0]     out_token_code;
  logic [CHAR_W-1:0]     out_lexeme_char;
  logic [LINE_OUT_W-1:0] out_line_number;
  logic                  out_last_of_run;

  basic_source_tokenizer_unit u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  string kw_names [KW_NUM] = '{
    "declare", "dim", "as", "type", "true", "false", "end", "sub",
    "function", "return", "if", "then", "elseif", "else", "for", "to",
    "step", "while", "input", "print", "and", "or", "not"
  };
  // single-character operators in code order from the left paren on
  string op_chars = "(),+-*/\\^=";
  string op_texts [15] = '{
    "(", ")", ",", "+", "-", "*", "/", "\\", "^", "=", "<>", "<=", ">=", "<", ">"
  };

  // lexer state
  mode_t                 scan_st    = M_IDLE;
  logic [CHAR_W-1:0]     word_chars [KW_MAX_LEN];
  logic [KW_LEN_W-1:0]   word_len   = '0;
  logic [LINE_OUT_W-1:0] lines_seen = '0;
  res_t                  lexer_out_q [$];
  int                    step_cnt;

  src_item_t source_q [$];
  int        sent_cnt     = 0;
  int        results_seen = 0;
  int        mismatches   = 0;
  int        hold_left    = 0;
  bit        hold_done    = 1'b0;
  int        cycles       = 0;

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [CODE_W-1:0] word_token();
    logic [CODE_W-1:0] code;
    bit                same;
    code = TK_IDENT;
    if (word_len <= KW_MAX_LEN) begin
      for (int k = 0; k < KW_NUM; k++) begin
        same = (kw_names[k].len() == int'(word_len));
        for (int i = 0; i < kw_names[k].len() && same; i++)
          if (kw_names[k][i] != word_chars[i]) same = 1'b0;
        if (same) code = TK_KW0 + CODE_W'(k);
      end
    end
    return code;
  endfunction

  task automatic push_tok(input logic kind, input logic [CODE_W-1:0] code,
                          input logic [CHAR_W-1:0] chr);
    res_t r;
    r.kind = kind;
    r.code = code;
    r.chr  = chr;
    r.line = lines_seen;
    r.last = 1'b0;
    lexer_out_q.push_back(r);
    step_cnt++;
  endtask

  task automatic add_word_char(input logic [7:0] c);
    if (word_len < KW_MAX_LEN) begin
      word_chars[word_len] = c;
      word_len++;
    end else begin
      word_len = KW_LEN_SAT;
    end
  endtask

  // predicts the results of one accepted transfer
  task automatic scan_char(input logic [7:0] c, input logic eoi);
    bit                fresh;
    logic [CODE_W-1:0] code;
    step_cnt = 0;
    fresh    = 1'b0;
    if (eoi) begin
      case (scan_st)
        M_INT:   push_tok(1'b0, TK_INT, '0);
        M_REAL:  push_tok(1'b0, TK_REAL, '0);
        M_WORD:  push_tok(1'b0, word_token(), '0);
        M_LT:    push_tok(1'b0, TK_LT, '0);
        M_GT:    push_tok(1'b0, TK_GT, '0);
        default: ;
      endcase
      push_tok(1'b0, TK_EOF, '0);
      scan_st  = M_IDLE;
      word_len = '0;
    end else begin
      case (scan_st)
        M_COMMENT: begin
          if (c == "\n") begin
            scan_st = M_IDLE;
            fresh   = 1'b1;
          end
        end
        M_INT: begin
          if (is_num(c)) begin
            push_tok(1'b1, '0, c);
          end else if (c == ".") begin
            scan_st = M_REAL;
            push_tok(1'b1, '0, c);
          end else begin
            push_tok(1'b0, TK_INT, '0);
            fresh = 1'b1;
          end
        end
        M_REAL: begin
          if (is_num(c)) begin
            push_tok(1'b1, '0, c);
          end else begin
            push_tok(1'b0, TK_REAL, '0);
            fresh = 1'b1;
          end
        end
        M_WORD: begin
          if (is_num(c) || is_letter(c)) begin
            add_word_char(fold_case(c));
            push_tok(1'b1, '0, fold_case(c));
          end else begin
            push_tok(1'b0, word_token(), '0);
            word_len = '0;
            fresh    = 1'b1;
          end
        end
        M_LT: begin
          scan_st = M_IDLE;
          if (c == ">") begin
            push_tok(1'b0, TK_NE, '0);
          end else if (c == "=") begin
            push_tok(1'b0, TK_LE, '0);
          end else begin
            push_tok(1'b0, TK_LT, '0);
            fresh = 1'b1;
          end
        end
        M_GT: begin
          scan_st = M_IDLE;
          if (c == "=") begin
            push_tok(1'b0, TK_GE, '0);
          end else begin
            push_tok(1'b0, TK_GT, '0);
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        scan_st = M_IDLE;
        if (c == " " || c == "\t") begin
        end else if (c == "'") begin
          scan_st = M_COMMENT;
        end else if (c == "\n") begin
          lines_seen++;
          push_tok(1'b0, TK_EOL, '0);
        end else if (is_num(c)) begin
          scan_st = M_INT;
          push_tok(1'b1, '0, c);
        end else if (is_letter(c)) begin
          scan_st  = M_WORD;
          word_len = '0;
          add_word_char(fold_case(c));
          push_tok(1'b1, '0, fold_case(c));
        end else if (c == "<") begin
          scan_st = M_LT;
        end else if (c == ">") begin
          scan_st = M_GT;
        end else begin
          code = TK_NULL;
          for (int i = 0; i < op_chars.len(); i++)
            if (op_chars[i] == c) code = TK_LPAREN + CODE_W'(i);
          push_tok(1'b0, code, '0);
        end
      end
    end
    if (step_cnt > 0) lexer_out_q[lexer_out_q.size()-1].last = 1'b1;
  endtask

  // source text generation
  task automatic add_char(input logic [7:0] c);
    src_item_t it;
    it.ch     = c;
    it.at_end = 1'b0;
    source_q.push_back(it);
  endtask

  task automatic add_end();
    src_item_t it;
    it.ch     = 8'($urandom);
    it.at_end = 1'b1;
    source_q.push_back(it);
  endtask

  task automatic add_text(input string s, input bit mixcase);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixcase && is_letter(c) && $urandom_range(1) == 1) c = c ^ 8'h20;
      add_char(c);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'("a" + $urandom_range(25)) ^ (($urandom_range(1) == 1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(1) == 1) ? 8'(" ") : 8'("\t");
  endfunction

  task automatic add_random_token();
    int    sel;
    int    n;
    string kw;
    sel = $urandom_range(99);
    if (sel < 20) begin
      add_text(kw_names[$urandom_range(KW_NUM-1)], 1'b1);
    end else if (sel < 26) begin
      // near-miss keywords: a prefix, or one character too many
      kw = kw_names[$urandom_range(KW_NUM-1)];
      if ($urandom_range(1) == 1) begin
        add_text(kw.substr(0, kw.len()-2), 1'b1);
      end else begin
        add_text(kw, 1'b1);
        add_char(($urandom_range(1) == 1) ? rand_letter() : rand_digit());
      end
    end else if (sel < 36) begin
      n = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      add_char(rand_letter());
      repeat (n - 1)
        add_char(($urandom_range(3) == 0) ? rand_digit() : rand_letter());
    end else if (sel < 46) begin
      repeat ($urandom_range(1, 5)) add_char(rand_digit());
    end else if (sel < 54) begin
      repeat ($urandom_range(1, 3)) add_char(rand_digit());
      add_char(".");
      repeat ($urandom_range(0, 3)) add_char(rand_digit());
      if ($urandom_range(5) == 0) add_char(".");
    end else if (sel < 72) begin
      add_text(op_texts[$urandom_range(14)], 1'b0);
    end else if (sel < 78) begin
      add_char("'");
      repeat ($urandom_range(0, 10)) add_char(8'($urandom_range(32, 126)));
      add_char("\n");
    end else if (sel < 86) begin
      if ($urandom_range(3) == 0) add_char("\r");
      add_char("\n");
    end else if (sel < 93) begin
      add_char(8'($urandom_range(255)));
    end else if (sel < 95) begin
      add_end();
    end else begin
      repeat ($urandom_range(1, 4)) add_char(rand_blank());
    end
    // tokens often abut so that each one ends the one before
    if ($urandom_range(1) == 1) add_char(rand_blank());
  endtask

  // input side
  always @(posedge clk) begin : drive
    src_item_t it;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_ch     <= '0;
      in_at_end <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_char(in_ch, in_at_end);
      if (!in_valid || in_ready) begin
        if (source_q.size() != 0 &&
            ((sent_cnt >= 300 && sent_cnt < 450) || $urandom_range(99) >= GAP_PCT)) begin
          it = source_q.pop_front();
          in_valid  <= 1'b1;
          in_ch     <= it.ch;
          in_at_end <= it.at_end;
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side backpressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_left <= 80;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (results_seen >= 300 && results_seen < 500) ||
                   $urandom_range(99) >= GAP_PCT;
    end
  end

  task automatic report(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: expected kind %0d code %0d char %h line %0d last %0d,",
                " got kind %0d code %0d char %h line %0d last %0d"},
               what, want.kind, want.code, want.chr, want.line, want.last,
               got.kind, got.code, got.chr, got.line, got.last);
  endtask

  always @(posedge clk) begin : check
    res_t got;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_token_code, out_lexeme_char, out_line_number, out_last_of_run};
      results_seen <= results_seen + 1;
      if (lexer_out_q.size() == 0) begin
        report("result with nothing expected", '0, got);
      end else begin
        want = lexer_out_q.pop_front();
        if (got.kind !== want.kind || got.code !== want.code || got.chr !== want.chr ||
            got.line !== want.line || got.last !== want.last)
          report("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("basic_source_tokenizer_unit test failed");
      $finish;
    end
  end

  initial begin
    // directed: char extremes, a real cut by a second dot, the two-character
    // operators, a keyword closed by a comment, carriage return, and end marks
    add_char(8'h00);
    add_char(8'hFF);
    add_text("12.5.", 1'b0);
    add_text("<>>=<=", 1'b0);
    add_text("WHILE'", 1'b0);
    add_char("x");
    add_char("\n");
    add_char("\r");
    add_char("<");
    add_end();
    add_end();
    while (source_q.size() < SOURCE_ITEMS) add_random_token();
    add_text("x1", 1'b0);
    add_end();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (source_q.size() != 0 || in_valid || lexer_out_q.size() != 0);
    repeat (16) @(negedge clk);
    if (mismatches == 0 && lexer_out_q.size() == 0)
      $display("basic_source_tokenizer_unit test passed");
    else
      $display("basic_source_tokenizer_unit test failed");
    $finish;
  end

endmodule

/* basic_source_tokenizer_unit.f */
src/bst_pkg.sv
src/bst_kw.sv
src/bst_scan.sv
src/bst_res_fifo.sv
src/basic_source_tokenizer_unit.sv
tb/testbench.sv
